// ===== sv/mdf_pkg.sv =====
// Shared types and constants of the MoldUDP64 packet deframer.
// No dependencies; the design modules and the checker import this package.
package mdf_pkg;

    // Header byte positions
    localparam logic [4:0] HDR_LEN   = 5'd20;
    localparam logic [4:0] SEQ_START = 5'd10;
    localparam logic [4:0] COUNT_HI  = 5'd18;
    localparam logic [4:0] COUNT_LO  = 5'd19;

    // Message block phase
    localparam logic [1:0] PH_LEN_HI  = 2'd0;
    localparam logic [1:0] PH_LEN_LO  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_FIRST   = 2'd3;

    // Packet disposition (codes match the status codes they report)
    localparam logic [1:0] DISP_DELIVER = 2'd0;
    localparam logic [1:0] DISP_DUP     = 2'd1;
    localparam logic [1:0] DISP_GAP     = 2'd2;

    // Result item kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Packet status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_GAP      = 3'd2;
    localparam logic [2:0] ST_OVERRUN  = 3'd3;
    localparam logic [2:0] ST_LEFTOVER = 3'd4;
    localparam logic [2:0] ST_SHORT    = 3'd5;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam logic [QCNT_W-1:0] QUEUE_ROOM_MAX = 3'd2;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  payload_byte;
        logic [63:0] message_seq;
        logic        first_of_message;
        logic        last_of_message;
        logic [2:0]  packet_status;
        logic        last_of_run;
    } result_t;

    // Results of one byte step, handed from the parser to the queue
    typedef struct packed {
        logic [1:0] count;
        result_t    item0;
        result_t    item1;
    } push_t;

endpackage

// ===== sv/mdf_in_if.sv =====
// Input channel of the deframer: one packet byte per item.
// Standalone interface; no package dependency.
interface mdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_packet;

    modport source (output valid, output data_byte, output last_of_packet, input ready);
    modport sink   (input valid, input data_byte, input last_of_packet, output ready);
endinterface

// ===== sv/mdf_out_if.sv =====
// Output channel of the deframer: one message byte, empty message or status per item.
// Standalone interface; no package dependency.
interface mdf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  payload_byte;
    logic [63:0] message_seq;
    logic        first_of_message;
    logic        last_of_message;
    logic [2:0]  packet_status;
    logic        last_of_run;

    modport source (output valid, output item_kind, output payload_byte, output message_seq,
                    output first_of_message, output last_of_message, output packet_status,
                    output last_of_run, input ready);
    modport sink   (input valid, input item_kind, input payload_byte, input message_seq,
                    input first_of_message, input last_of_message, input packet_status,
                    input last_of_run, output ready);
endinterface

// ===== sv/moldudp64_packet_deframer_top.sv =====
// Top level of the MoldUDP64 packet deframer; instantiates mdf_parser and mdf_result_queue.
// Depends on mdf_pkg, mdf_in_if and mdf_out_if.
//
// Feed packet bytes on pkt_in, header first, with last_of_packet on the final byte.
// The block takes one byte per cycle while pkt_in.ready is high: each byte passes an
// input register, is parsed against the running packet state, and its results (at
// most two: one message byte or empty-message item, then a status item on the last
// byte) enter a four-entry result queue that drives msg_out. pkt_in.ready drops only
// when the queue holds more than two items, so a sink that takes one item per cycle
// sees a full byte-per-cycle rate; header bytes and bytes of dropped packets give no
// result and let the queue drain. The expected sequence is set by the first packet;
// duplicate and gap packets are dropped whole and reported by status, old messages
// inside a delivered packet are skipped, and every packet ends with one status item,
// which carries the header sequence unless the packet is short.
module moldudp64_packet_deframer_top (
    input  logic       clk,
    input  logic       rst_n,
    mdf_in_if.sink     pkt_in,
    mdf_out_if.source  msg_out
);
    import mdf_pkg::*;

    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;
    logic       room;
    logic       advance;
    logic       accept;
    logic       head_valid;
    logic       pop;
    push_t      push;
    result_t    head;

    // Advance the staged byte only when the queue can absorb two results
    assign advance      = stage_valid_reg && room;
    assign pkt_in.ready = !stage_valid_reg || room;
    assign accept       = pkt_in.valid && pkt_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Hold the byte payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_byte_reg <= pkt_in.data_byte;
            stage_last_reg <= pkt_in.last_of_packet;
        end
    end

    mdf_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .data_byte      (stage_byte_reg),
        .last_of_packet (stage_last_reg),
        .push           (push)
    );

    mdf_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    assign pop                      = head_valid && msg_out.ready;
    assign msg_out.valid            = head_valid;
    assign msg_out.item_kind        = head.item_kind;
    assign msg_out.payload_byte     = head.payload_byte;
    assign msg_out.message_seq      = head.message_seq;
    assign msg_out.first_of_message = head.first_of_message;
    assign msg_out.last_of_message  = head.last_of_message;
    assign msg_out.packet_status    = head.packet_status;
    assign msg_out.last_of_run      = head.last_of_run;

endmodule

// ===== sv/mdf_parser.sv =====
// Packet parser of the deframer: header, sequence tracking and message blocks.
// Depends on mdf_pkg; produces up to two results per byte step.
module mdf_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     data_byte,
    input  logic           last_of_packet,
    output mdf_pkg::push_t push
);
    import mdf_pkg::*;

    logic [4:0]  offset_reg, offset_next;
    logic [63:0] pkt_seq_reg, pkt_seq_next;
    logic [15:0] msgs_reg, msgs_next;
    logic [7:0]  lenhi_reg, lenhi_next;
    logic [15:0] left_reg, left_next;
    logic [1:0]  phase_reg, phase_next;
    logic [63:0] cur_reg, cur_next;
    logic [63:0] exp_reg, exp_next;
    logic        first_seen_reg, first_seen_next;
    logic [1:0]  disp_reg, disp_next;
    logic        leftover_reg, leftover_next;

    logic [15:0] count_word;
    logic [15:0] len_word;
    logic [15:0] left_dec;
    logic [63:0] seq_sum;
    logic [63:0] eff_exp;
    logic        old_dup;
    logic [1:0]  class_disp;
    logic        skip;
    logic        emit_msg;
    logic        emit_st;
    result_t     msg_item;
    result_t     st_item;

    // Header classification: one add, then parallel compares
    assign count_word = {msgs_reg[15:8], data_byte};
    assign len_word   = {lenhi_reg, data_byte};
    assign left_dec   = left_reg - 16'd1;
    assign seq_sum    = pkt_seq_reg + {48'd0, count_word};
    assign eff_exp    = first_seen_reg ? exp_reg : pkt_seq_reg;
    assign old_dup    = (seq_sum <= exp_reg);
    assign skip       = (cur_reg < exp_reg);

    always_comb
    begin
        if (old_dup || (seq_sum <= eff_exp))
        begin
            class_disp = DISP_DUP;
        end
        else if (pkt_seq_reg > eff_exp)
        begin
            class_disp = DISP_GAP;
        end
        else
        begin
            class_disp = DISP_DELIVER;
        end
    end

    always_comb
    begin
        offset_next     = offset_reg;
        pkt_seq_next    = pkt_seq_reg;
        msgs_next       = msgs_reg;
        lenhi_next      = lenhi_reg;
        left_next       = left_reg;
        phase_next      = phase_reg;
        cur_next        = cur_reg;
        exp_next        = exp_reg;
        first_seen_next = first_seen_reg;
        disp_next       = disp_reg;
        leftover_next   = leftover_reg;
        emit_msg        = 1'b0;
        emit_st         = 1'b0;
        msg_item        = '0;
        st_item         = '0;

        if (offset_reg < HDR_LEN)
        begin
            offset_next = offset_reg + 5'd1;
            if (offset_reg >= SEQ_START && offset_reg < COUNT_HI)
            begin
                pkt_seq_next = {pkt_seq_reg[55:0], data_byte};
            end
            else if (offset_reg == COUNT_HI)
            begin
                msgs_next = {data_byte, 8'd0};
            end
            else if (offset_reg == COUNT_LO)
            begin
                msgs_next = count_word;
                disp_next = class_disp;
                if (!old_dup && !first_seen_reg)
                begin
                    exp_next        = pkt_seq_reg;
                    first_seen_next = 1'b1;
                end
                if (class_disp == DISP_DELIVER)
                begin
                    cur_next = pkt_seq_reg;
                end
            end
        end
        else if (disp_reg == DISP_DELIVER)
        begin
            if (msgs_reg == 16'd0)
            begin
                leftover_next = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN_HI:
                    begin
                        lenhi_next = data_byte;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        left_next = len_word;
                        if (len_word == 16'd0)
                        begin
                            emit_msg             = !skip;
                            msg_item.item_kind   = KIND_EMPTY;
                            msg_item.message_seq = cur_reg;
                            cur_next             = cur_reg + 64'd1;
                            msgs_next            = msgs_reg - 16'd1;
                            phase_next           = PH_LEN_HI;
                        end
                        else
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    PH_PAYLOAD, PH_FIRST:
                    begin
                        left_next                 = left_dec;
                        emit_msg                  = !skip;
                        msg_item.item_kind        = KIND_PAYLOAD;
                        msg_item.payload_byte     = data_byte;
                        msg_item.message_seq      = cur_reg;
                        msg_item.first_of_message = (phase_reg == PH_FIRST);
                        msg_item.last_of_message  = (left_dec == 16'd0);
                        if (left_dec == 16'd0)
                        begin
                            cur_next   = cur_reg + 64'd1;
                            msgs_next  = msgs_reg - 16'd1;
                            phase_next = PH_LEN_HI;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                endcase
            end
        end

        if (last_of_packet)
        begin
            emit_st             = 1'b1;
            st_item.item_kind   = KIND_STATUS;
            st_item.last_of_run = 1'b1;
            if (offset_reg < COUNT_LO)
            begin
                st_item.packet_status = ST_SHORT;
            end
            else if (disp_next != DISP_DELIVER)
            begin
                st_item.packet_status = {1'b0, disp_next};
                st_item.message_seq   = pkt_seq_next;
            end
            else
            begin
                if (msgs_next != 16'd0 || phase_next != PH_LEN_HI)
                begin
                    st_item.packet_status = ST_OVERRUN;
                end
                else if (leftover_next)
                begin
                    st_item.packet_status = ST_LEFTOVER;
                end
                else
                begin
                    st_item.packet_status = ST_OK;
                end
                st_item.message_seq = pkt_seq_next;
                // cur + msgs is unchanged by finishing a message, so use the sum of the registered values
                if (offset_reg == COUNT_LO)
                begin
                    exp_next = seq_sum;
                end
                else
                begin
                    exp_next = cur_reg + {48'd0, msgs_reg};
                end
            end
            // drop all per-packet state
            offset_next   = '0;
            pkt_seq_next  = '0;
            msgs_next     = '0;
            lenhi_next    = '0;
            left_next     = '0;
            phase_next    = PH_LEN_HI;
            cur_next      = '0;
            disp_next     = DISP_DELIVER;
            leftover_next = 1'b0;
        end

        msg_item.last_of_run = !emit_st;
    end

    assign push.count = step ? ({1'b0, emit_msg} + {1'b0, emit_st}) : 2'd0;
    assign push.item0 = emit_msg ? msg_item : st_item;
    assign push.item1 = st_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            pkt_seq_reg    <= '0;
            msgs_reg       <= '0;
            lenhi_reg      <= '0;
            left_reg       <= '0;
            phase_reg      <= PH_LEN_HI;
            cur_reg        <= '0;
            exp_reg        <= '0;
            first_seen_reg <= 1'b0;
            disp_reg       <= DISP_DELIVER;
            leftover_reg   <= 1'b0;
        end
        else if (step)
        begin
            offset_reg     <= offset_next;
            pkt_seq_reg    <= pkt_seq_next;
            msgs_reg       <= msgs_next;
            lenhi_reg      <= lenhi_next;
            left_reg       <= left_next;
            phase_reg      <= phase_next;
            cur_reg        <= cur_next;
            exp_reg        <= exp_next;
            first_seen_reg <= first_seen_next;
            disp_reg       <= disp_next;
            leftover_reg   <= leftover_next;
        end
    end

endmodule

// ===== sv/mdf_result_queue.sv =====
// Four-entry result queue: takes up to two items per cycle, gives one.
// Depends on mdf_pkg.
module mdf_result_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  mdf_pkg::push_t  push,
    output logic            room,
    output logic            head_valid,
    output mdf_pkg::result_t head,
    input  logic            pop
);
    import mdf_pkg::*;

    result_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_plus1;

    assign room         = (count_reg <= QUEUE_ROOM_MAX);
    assign head_valid   = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + {{(QPTR_W-1){1'b0}}, 1'b1};
    assign wr_ptr_next  = wr_ptr_reg + push.count[QPTR_W-1:0];
    assign rd_ptr_next  = rd_ptr_reg + {{(QPTR_W-1){1'b0}}, pop};
    assign count_next   = count_reg + {{(QCNT_W-2){1'b0}}, push.count}
                                    - {{(QCNT_W-1){1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/mdf_checker.sv =====
// Port-level checker of the deframer and its bind to the top level.
// Depends on mdf_pkg and moldudp64_packet_deframer_top.
module mdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  item_kind,
    input logic [7:0]  payload_byte,
    input logic [63:0] message_seq,
    input logic        first_of_message,
    input logic        last_of_message,
    input logic [2:0]  packet_status,
    input logic        last_of_run
);
    import mdf_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind)
            && $stable(message_seq) && $stable(payload_byte) && $stable(last_of_run))
        else $error("stalled result changed");

    // A status item always closes the run of its byte and carries no message flags
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_STATUS |-> last_of_run && !first_of_message
            && !last_of_message && payload_byte == 8'd0)
        else $error("malformed status item");

    // Message items carry no packet status and a known kind
    a_msg_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != KIND_STATUS |-> packet_status == ST_OK
            && (item_kind == KIND_PAYLOAD || item_kind == KIND_EMPTY))
        else $error("message item with status or bad kind");

    // An empty message has no byte flags
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_EMPTY |-> !first_of_message && !last_of_message
            && payload_byte == 8'd0)
        else $error("malformed empty-message item");

endmodule

bind moldudp64_packet_deframer_top mdf_checker u_mdf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (msg_out.valid),
    .out_ready        (msg_out.ready),
    .item_kind        (msg_out.item_kind),
    .payload_byte     (msg_out.payload_byte),
    .message_seq      (msg_out.message_seq),
    .first_of_message (msg_out.first_of_message),
    .last_of_message  (msg_out.last_of_message),
    .packet_status    (msg_out.packet_status),
    .last_of_run      (msg_out.last_of_run)
);
